// ===== rtl/core/iuc_pkg.sv =====
package iuc_pkg;

    localparam int IDX_W   = 10;
    localparam int POS_W   = 31;
    localparam int STR_W   = 2;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 32;
    localparam int SPAN_W  = 16;
    localparam int EIU_W   = 11;
    localparam int CFGI_W  = 1;
    localparam int IN_W    = 80;
    localparam int OUT_W   = 104;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_SEG  = 2'd1;
    localparam logic [OP_W-1:0] OP_QRY  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_ORDER = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic [STR_W-1:0] STR_PLUS  = 2'd0;
    localparam logic [STR_W-1:0] STR_MINUS = 2'd1;
    localparam logic [STR_W-1:0] STR_NONE  = 2'd2;
    localparam logic [STR_W-1:0] STR_OTHER = 2'd3;

    localparam logic [CFGI_W-1:0] CFG_MIN_SPAN = 1'b0;
    localparam logic [CFGI_W-1:0] CFG_ENTRIES  = 1'b1;

    typedef struct packed {
        logic [STR_W-1:0] strand;
        logic [POS_W-1:0] iend;
        logic [POS_W-1:0] istart;
    } t_ival;

    typedef struct packed {
        logic [CNT_W-1:0] incl;
        logic [CNT_W-1:0] cont;
        logic [CNT_W-1:0] skip;
        logic             imark;
        logic             cmark;
    } t_cnt;

    typedef struct packed {
        logic incl;
        logic cont;
    } t_olap;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/core/iuc_ram.sv =====
module iuc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/iuc_olap.sv =====
module iuc_olap (
    input  logic [iuc_pkg::POS_W-1:0]  i_s,
    input  logic [iuc_pkg::POS_W-1:0]  i_e,
    input  iuc_pkg::t_ival             i_iv,
    input  logic [iuc_pkg::SPAN_W-1:0] i_span,
    output iuc_pkg::t_olap             o_res
);
    import iuc_pkg::*;

    logic signed [POS_W+1:0] w_s, w_e, w_is, w_ie, w_sp;
    logic signed [POS_W+1:0] w_lo, w_hi, w_ov, w_ls, w_rs;

    always_comb begin
        w_s  = $signed({2'b00, i_s});
        w_e  = $signed({2'b00, i_e});
        w_is = $signed({2'b00, i_iv.istart});
        w_ie = $signed({2'b00, i_iv.iend});
        w_sp = $signed({{(POS_W+2-SPAN_W){1'b0}}, i_span});
        w_lo = (w_is > w_s) ? w_is : w_s;
        w_hi = (w_ie < w_e) ? w_ie : w_e;
        w_ov = w_hi - w_lo;
        w_ls = w_is - w_s;
        w_rs = w_e - w_ie;
        o_res.incl = (w_ov >= w_sp) && ((w_ls >= w_sp) || (w_rs >= w_sp));
        o_res.cont = (w_ov >= w_sp) && (w_ls <= 0) && (w_rs <= 0);
    end

endmodule

// ===== rtl/core/intron_usage_counter.sv =====
// Interval usage counter. Intervals are loaded (op 0, tuser) in ascending start
// order; read segments (op 1) mark overlapping intervals and count junction skips;
// queries (op 2) return the three saturating counters. One beat in, one beat out.
// A segment reads and evaluates each table entry walked from the guide index,
// then scans entries downward from the last entry in use for a skip match when
// both flanking segments exceed min_span, and on the last segment of a read (or
// a restarted read) reads and rewrites each entry in the read's marked range to
// commit or clear marks. Each memory has one write port and one read port, and
// the read address is shared. After reset a clearing pass over all TABLE_DEPTH
// entries zeroes the counters while no beat is taken.
module intron_usage_counter #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [iuc_pkg::CFGI_W-1:0]  i_cfg_idx,
    input  logic [iuc_pkg::SPAN_W-1:0]  i_cfg_wdata,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // entry_index, seg_start, seg_end, strand_code, read_first, zero pad
    input  logic [iuc_pkg::IN_W-1:0]    i_s_tdata,
    // op
    input  logic [iuc_pkg::OP_W-1:0]    i_s_tuser,
    input  logic                        i_s_tlast,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // status, inclusion_count, containment_count, skip_count, zero pad
    output logic [iuc_pkg::OUT_W-1:0]   o_m_tdata
);
    import iuc_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [13:0] {
        S_INIT  = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_QRY   = 14'b00000000000100,
        S_W1_RD = 14'b00000000001000,
        S_W1_EV = 14'b00000000010000,
        S_W2_RD = 14'b00000000100000,
        S_W2_EV = 14'b00000001000000,
        S_WEND  = 14'b00000010000000,
        S_SK_RD = 14'b00000100000000,
        S_SK_EV = 14'b00001000000000,
        S_SKEND = 14'b00010000000000,
        S_SW_RD = 14'b00100000000000,
        S_SW_WR = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic [SPAN_W-1:0] r_min_span;
    logic [EIU_W-1:0]  r_entries;

    logic [CW-1:0] r_i, n_i, r_k, n_k, r_sw_end, n_sw_end;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [CW-1:0] r_read_guide, n_read_guide, r_seg_guide, n_seg_guide;
    logic [POS_W-1:0] r_prev_s, n_prev_s, r_prev_e, n_prev_e;
    logic [POS_W-1:0] r_last_start, n_last_start;
    logic r_prev_valid, n_prev_valid, r_read_open, n_read_open;
    logic r_sw_commit, n_sw_commit, r_then_walk, n_then_walk;
    logic r_want_p, n_want_p, r_want_m, n_want_m;

    logic [POS_W-1:0] r_s, n_s, r_e, n_e;
    logic [STR_W-1:0] r_strand, n_strand;
    logic r_last, n_last;

    logic [STAT_W-1:0] r_status, n_status;
    logic [CNT_W-1:0]  r_c_incl, n_c_incl, r_c_cont, n_c_cont, r_c_skip, n_c_skip;

    logic              r_ovalid, n_ovalid;
    logic [OUT_W-1:0]  r_odata, n_odata;

    logic [OP_W-1:0]   w_op;
    logic [IDX_W-1:0]  w_idx;
    logic [POS_W-1:0]  w_in_s, w_in_e;
    logic [STR_W-1:0]  w_in_str;
    logic              w_in_first, w_idx_ok, w_accept;
    logic [CW-1:0]     w_n;

    logic          w_iv_we, w_cn_we;
    logic [AW-1:0] w_iv_waddr, w_cn_waddr, w_raddr;
    t_ival         w_iv_wdata, w_iv_rdata;
    t_cnt          w_cn_wdata, w_cn_rdata;
    t_olap         w_ol;
    logic          w_str_ok;
    logic signed [POS_W+1:0] w_plen, w_clen, w_sp;

    assign w_op       = i_s_tuser;
    assign w_idx      = i_s_tdata[IDX_W-1:0];
    assign w_in_s     = i_s_tdata[IDX_W +: POS_W];
    assign w_in_e     = i_s_tdata[IDX_W+POS_W +: POS_W];
    assign w_in_str   = i_s_tdata[IDX_W+2*POS_W +: STR_W];
    assign w_in_first = i_s_tdata[IDX_W+2*POS_W+STR_W];
    assign w_idx_ok   = 32'(w_idx) < TABLE_DEPTH;
    assign w_n        = (32'(r_entries) < TABLE_DEPTH) ? CW'(r_entries) : CW'(TABLE_DEPTH);

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    assign w_str_ok = r_strand[1] || (r_strand == w_iv_rdata.strand);
    assign w_sp     = $signed({{(POS_W+2-SPAN_W){1'b0}}, r_min_span});
    assign w_plen   = $signed({2'b00, r_prev_e}) - $signed({2'b00, r_prev_s});
    assign w_clen   = $signed({2'b00, r_e}) - $signed({2'b00, r_s});

    iuc_ram #(.WIDTH($bits(t_ival)), .DEPTH(TABLE_DEPTH)) u_ival_ram (
        .i_clk   (i_clk),
        .i_we    (w_iv_we),
        .i_waddr (w_iv_waddr),
        .i_wdata (w_iv_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_iv_rdata)
    );

    iuc_ram #(.WIDTH($bits(t_cnt)), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cn_we),
        .i_waddr (w_cn_waddr),
        .i_wdata (w_cn_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_cn_rdata)
    );

    iuc_olap u_olap (
        .i_s    (r_s),
        .i_e    (r_e),
        .i_iv   (w_iv_rdata),
        .i_span (r_min_span),
        .o_res  (w_ol)
    );

    always_comb begin
        n_state      = r_state;
        n_i          = r_i;
        n_k          = r_k;
        n_sw_end     = r_sw_end;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_read_guide = r_read_guide;
        n_seg_guide  = r_seg_guide;
        n_prev_s     = r_prev_s;
        n_prev_e     = r_prev_e;
        n_last_start = r_last_start;
        n_prev_valid = r_prev_valid;
        n_read_open  = r_read_open;
        n_sw_commit  = r_sw_commit;
        n_then_walk  = r_then_walk;
        n_want_p     = r_want_p;
        n_want_m     = r_want_m;
        n_s          = r_s;
        n_e          = r_e;
        n_strand     = r_strand;
        n_last       = r_last;
        n_status     = r_status;
        n_c_incl     = r_c_incl;
        n_c_cont     = r_c_cont;
        n_c_skip     = r_c_skip;
        n_ovalid     = r_ovalid && !i_m_tready;
        n_odata      = r_odata;

        w_raddr    = r_i[AW-1:0];
        w_iv_we    = 1'b0;
        w_iv_waddr = AW'(w_idx);
        w_iv_wdata = '{strand: w_in_str, iend: w_in_e, istart: w_in_s};
        w_cn_we    = 1'b0;
        w_cn_waddr = r_i[AW-1:0];
        w_cn_wdata = w_cn_rdata;

        unique case (r_state)
            S_INIT: begin
                w_cn_we    = 1'b1;
                w_cn_waddr = r_k[AW-1:0];
                w_cn_wdata = '0;
                n_k        = r_k + 1'b1;
                if (r_k == CW'(TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_s      = w_in_s;
                    n_e      = w_in_e;
                    n_strand = w_in_str;
                    n_last   = i_s_tlast;
                    n_status = ST_OK;
                    n_c_incl = '0;
                    n_c_cont = '0;
                    n_c_skip = '0;
                    n_state  = S_DONE;
                    if (w_op == OP_LOAD || w_op == OP_QRY) begin
                        if (!w_idx_ok) begin
                            n_status = ST_RANGE;
                        end else if (w_op == OP_LOAD) begin
                            w_iv_we    = 1'b1;
                            w_cn_we    = 1'b1;
                            w_cn_waddr = AW'(w_idx);
                            w_cn_wdata = '0;
                        end else begin
                            w_raddr = AW'(w_idx);
                            n_state = S_QRY;
                        end
                    end else if (w_op == OP_SEG) begin
                        if (w_in_first) begin
                            // drop marks of an unfinished read before anything else
                            n_prev_valid = 1'b0;
                            n_k          = r_lo;
                            n_sw_end     = r_hi;
                            n_sw_commit  = 1'b0;
                            if (w_in_s < r_last_start) begin
                                n_status    = ST_ORDER;
                                n_read_open = 1'b0;
                                n_then_walk = 1'b0;
                            end else begin
                                n_last_start = w_in_s;
                                n_seg_guide  = r_read_guide;
                                n_read_open  = 1'b1;
                                n_lo         = r_read_guide;
                                n_hi         = r_read_guide;
                                n_i          = r_read_guide;
                                n_then_walk  = 1'b1;
                            end
                            if (r_read_open) begin
                                n_state = S_SW_RD;
                            end else if (w_in_s >= r_last_start) begin
                                n_state = S_W1_RD;
                            end
                        end else if (r_read_open) begin
                            n_i     = r_seg_guide;
                            n_state = S_W1_RD;
                        end
                    end
                end
            end
            S_QRY: begin
                n_c_incl = w_cn_rdata.incl;
                n_c_cont = w_cn_rdata.cont;
                n_c_skip = w_cn_rdata.skip;
                n_state  = S_DONE;
            end
            S_W1_RD: begin
                if (r_i < w_n) begin
                    n_state = S_W1_EV;
                end else begin
                    n_seg_guide = r_i;
                    if (!r_prev_valid) begin
                        n_read_guide = r_i;
                    end
                    n_state = S_WEND;
                end
            end
            S_W1_EV: begin
                if ({1'b0, w_iv_rdata.iend} <= {1'b0, r_s}) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_W1_RD;
                end else begin
                    n_seg_guide = r_i;
                    if (!r_prev_valid) begin
                        n_read_guide = r_i;
                    end
                    n_state = S_W2_EV;
                end
            end
            S_W2_RD: begin
                n_state = (r_i < w_n) ? S_W2_EV : S_WEND;
            end
            S_W2_EV: begin
                if (w_iv_rdata.istart < r_e) begin
                    if (w_str_ok && (w_ol.incl || w_ol.cont)) begin
                        w_cn_we          = 1'b1;
                        w_cn_wdata.imark = w_cn_rdata.imark | w_ol.incl;
                        w_cn_wdata.cmark = w_cn_rdata.cmark | w_ol.cont;
                    end
                    n_i     = r_i + 1'b1;
                    n_state = S_W2_RD;
                end else begin
                    n_state = S_WEND;
                end
            end
            S_WEND: begin
                if (r_i > r_hi) begin
                    n_hi = r_i;
                end
                n_k = w_n;
                if (r_prev_valid && (w_plen > w_sp) && (w_clen > w_sp)) begin
                    n_want_p = (r_strand == STR_PLUS) || r_strand[1];
                    n_want_m = (r_strand == STR_MINUS) || r_strand[1];
                end else begin
                    n_want_p = 1'b0;
                    n_want_m = 1'b0;
                end
                n_state = S_SK_RD;
            end
            S_SK_RD: begin
                w_raddr = r_k[AW-1:0] - 1'b1;
                if (r_k == '0 || !(r_want_p || r_want_m)) begin
                    n_state = S_SKEND;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_state = S_SK_EV;
                end
            end
            S_SK_EV: begin
                // the highest matching index of each strand takes the skip
                w_cn_waddr = r_k[AW-1:0];
                if (w_iv_rdata.istart == r_prev_e && w_iv_rdata.iend == r_s) begin
                    if (r_want_p && w_iv_rdata.strand == STR_PLUS) begin
                        w_cn_we         = 1'b1;
                        w_cn_wdata.skip = sat_inc(w_cn_rdata.skip);
                        n_want_p        = 1'b0;
                    end
                    if (r_want_m && w_iv_rdata.strand == STR_MINUS) begin
                        w_cn_we         = 1'b1;
                        w_cn_wdata.skip = sat_inc(w_cn_rdata.skip);
                        n_want_m        = 1'b0;
                    end
                end
                n_state = S_SK_RD;
            end
            S_SKEND: begin
                n_prev_s     = r_s;
                n_prev_e     = r_e;
                n_prev_valid = 1'b1;
                n_state      = S_DONE;
                if (r_last) begin
                    n_read_open  = 1'b0;
                    n_prev_valid = 1'b0;
                    n_k          = r_lo;
                    n_sw_end     = r_hi;
                    n_sw_commit  = 1'b1;
                    n_then_walk  = 1'b0;
                    n_state      = S_SW_RD;
                end
            end
            S_SW_RD: begin
                w_raddr = r_k[AW-1:0];
                if (r_k < r_sw_end) begin
                    n_state = S_SW_WR;
                end else begin
                    n_state = r_then_walk ? S_W1_RD : S_DONE;
                end
            end
            S_SW_WR: begin
                w_cn_we          = 1'b1;
                w_cn_waddr       = r_k[AW-1:0];
                w_cn_wdata.imark = 1'b0;
                w_cn_wdata.cmark = 1'b0;
                if (r_sw_commit && w_cn_rdata.imark) begin
                    w_cn_wdata.incl = sat_inc(w_cn_rdata.incl);
                end
                if (r_sw_commit && w_cn_rdata.cmark) begin
                    w_cn_wdata.cont = sat_inc(w_cn_rdata.cont);
                end
                n_k     = r_k + 1'b1;
                n_state = S_SW_RD;
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {{(OUT_W-STAT_W-3*CNT_W){1'b0}},
                                r_c_skip, r_c_cont, r_c_incl, r_status};
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_min_span   <= SPAN_W'(6);
            r_entries    <= '0;
            r_k          <= '0;
            r_lo         <= '0;
            r_hi         <= '0;
            r_read_guide <= '0;
            r_seg_guide  <= '0;
            r_prev_s     <= '0;
            r_prev_e     <= '0;
            r_last_start <= '0;
            r_prev_valid <= 1'b0;
            r_read_open  <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_k          <= n_k;
            r_lo         <= n_lo;
            r_hi         <= n_hi;
            r_read_guide <= n_read_guide;
            r_seg_guide  <= n_seg_guide;
            r_prev_s     <= n_prev_s;
            r_prev_e     <= n_prev_e;
            r_last_start <= n_last_start;
            r_prev_valid <= n_prev_valid;
            r_read_open  <= n_read_open;
            r_ovalid     <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_SPAN: r_min_span <= i_cfg_wdata;
                    CFG_ENTRIES:  r_entries  <= i_cfg_wdata[EIU_W-1:0];
                    default:      r_entries  <= r_entries;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_sw_end    <= n_sw_end;
        r_sw_commit <= n_sw_commit;
        r_then_walk <= n_then_walk;
        r_want_p    <= n_want_p;
        r_want_m    <= n_want_m;
        r_s         <= n_s;
        r_e         <= n_e;
        r_strand    <= n_strand;
        r_last      <= n_last;
        r_status    <= n_status;
        r_c_incl    <= n_c_incl;
        r_c_cont    <= n_c_cont;
        r_c_skip    <= n_c_skip;
        r_odata     <= n_odata;
    end

endmodule

// ===== rtl/core/iuc_checker.sv =====
module iuc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [iuc_pkg::OUT_W-1:0]   o_m_tdata
);
    import iuc_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while previous item in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[STAT_W-1:0] <= ST_RANGE)
        else $error("undefined status code");

    // counters are only reported with an ok status
    a_status_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[STAT_W-1:0] != ST_OK |->
        o_m_tdata[STAT_W +: 3*CNT_W] == '0)
        else $error("counters reported with error status");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("handshake active after reset");

endmodule

bind intron_usage_counter iuc_checker u_iuc_checker (.*);
